>>> rtl/assert_macros.svh
// assertion macros used by the rtl files
// expects clk and rst to exist in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define KFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kfc_pkg.sv
// shared types and constants for the keyed fifo with cancel
// no dependencies
`default_nettype none

package kfc_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_W       = 31;
  localparam int HANDLE_W    = 16;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_FIND   = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/kfc_store.sv
// entry memory: one write port, one read port with registered data
// depends on kfc_pkg
`default_nettype none

module kfc_store #(
  parameter int DEPTH = kfc_pkg::QUEUE_DEPTH,
  parameter int AW    = $clog2(kfc_pkg::QUEUE_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire kfc_pkg::entry_t wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output kfc_pkg::entry_t      rd_data
);

  kfc_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/keyed_fifo_with_cancel.sv
// keyed fifo with cancel: top level, command sequencer and shared key compare
// depends on kfc_pkg, kfc_store and assert_macros.svh
//
//   channel  | handshake          | fields
//   ---------+--------------------+--------------------------------------------
//   command  | start / busy       | opcode, entry_key, entry_handle
//   result   | done (one cycle)   | status, found_handle, found_key, queue_empty
//
// push, unused opcodes and every command that fails at once (empty, full)
// finish from idle: the result strobes on the next cycle and busy never rises.
// pop, peek, find and remove walk the memory through its single read port,
// addressing each slot in S_LOOK and checking its data in S_CHECK; on a hit,
// pop and remove then move each later entry up via S_SHIFT_RD and S_SHIFT_WR.
// reset clears occupancy and the sequencer; the memory needs no clearing since
// only slots below occupancy are ever read.
// results cannot be stalled: each one is on the ports for the single done cycle.
`default_nettype none

module keyed_fifo_with_cancel #(
  parameter int QUEUE_DEPTH = kfc_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   opcode,
  input  wire logic [kfc_pkg::KEY_W-1:0]    entry_key,
  input  wire logic [kfc_pkg::HANDLE_W-1:0] entry_handle,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [kfc_pkg::HANDLE_W-1:0]      found_handle,
  output logic [kfc_pkg::KEY_W-1:0]         found_key,
  output logic                              queue_empty
);

  `include "assert_macros.svh"

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OW-1:0] FULL_COUNT = OW'(QUEUE_DEPTH);

  // sequencer registers
  kfc_pkg::state_t state, state_next;
  kfc_pkg::op_t    op, op_next;
  logic [kfc_pkg::KEY_W-1:0] key, key_next;
  logic [OW-1:0]   idx, idx_next;
  logic [OW-1:0]   occ, occ_next;

  // result registers
  logic                          done_next;
  logic [1:0]                    status_next;
  logic [kfc_pkg::HANDLE_W-1:0]  found_handle_next;
  logic [kfc_pkg::KEY_W-1:0]     found_key_next;
  logic                          queue_empty_next;

  // memory port
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  kfc_pkg::entry_t wr_data;
  logic [AW-1:0]   rd_addr;
  kfc_pkg::entry_t rd_data;

  logic [OW-1:0] idx_inc;
  logic          key_hit;
  logic          take_any;

  assign busy    = (state != kfc_pkg::S_IDLE);
  assign idx_inc = idx + OW'(1);

  // the one shared compare: pop and peek take the head whatever its key
  assign take_any = (op == kfc_pkg::OP_POP) || (op == kfc_pkg::OP_PEEK);
  assign key_hit  = take_any || (rd_data.key == key);

  kfc_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kfc_pkg::S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      done  <= done_next;
    end
  end

  // payload and scan registers need no reset
  always_ff @(posedge clk) begin
    op           <= op_next;
    key          <= key_next;
    idx          <= idx_next;
    status       <= status_next;
    found_handle <= found_handle_next;
    found_key    <= found_key_next;
    queue_empty  <= queue_empty_next;
  end

  always_comb begin
    state_next        = state;
    op_next           = op;
    key_next          = key;
    idx_next          = idx;
    occ_next          = occ;
    done_next         = 1'b0;
    status_next       = status;
    found_handle_next = found_handle;
    found_key_next    = found_key;
    queue_empty_next  = queue_empty;
    wr_en             = 1'b0;
    wr_addr           = idx[AW-1:0];
    wr_data           = rd_data;
    rd_addr           = idx[AW-1:0];

    case (state)
      kfc_pkg::S_IDLE: begin
        if (start) begin
          // default result: ok with no entry, for push and unused opcodes
          done_next         = 1'b1;
          status_next       = kfc_pkg::ST_OK;
          found_handle_next = '0;
          found_key_next    = '0;
          queue_empty_next  = (occ == '0);
          case (opcode)
            kfc_pkg::OP_PUSH: begin
              if (occ == FULL_COUNT) begin
                status_next = kfc_pkg::ST_FULL;
              end else begin
                wr_en            = 1'b1;
                wr_addr          = occ[AW-1:0];
                wr_data.key      = entry_key;
                wr_data.handle   = entry_handle;
                occ_next         = occ + OW'(1);
                queue_empty_next = 1'b0;
              end
            end
            kfc_pkg::OP_POP, kfc_pkg::OP_PEEK: begin
              if (occ == '0) begin
                status_next = kfc_pkg::ST_EMPTY;
              end else begin
                done_next  = 1'b0;
                op_next    = kfc_pkg::op_t'(opcode);
                idx_next   = '0;
                state_next = kfc_pkg::S_LOOK;
              end
            end
            kfc_pkg::OP_FIND, kfc_pkg::OP_REMOVE: begin
              if (occ == '0) begin
                status_next = kfc_pkg::ST_NOTFOUND;
              end else begin
                done_next  = 1'b0;
                op_next    = kfc_pkg::op_t'(opcode);
                key_next   = entry_key;
                idx_next   = '0;
                state_next = kfc_pkg::S_LOOK;
              end
            end
            default: begin
              // unused opcode: queue untouched
            end
          endcase
        end
      end

      kfc_pkg::S_LOOK: begin
        // address slot idx, data comes back next cycle
        rd_addr    = idx[AW-1:0];
        state_next = kfc_pkg::S_CHECK;
      end

      kfc_pkg::S_CHECK: begin
        if (key_hit) begin
          found_key_next    = rd_data.key;
          found_handle_next = rd_data.handle;
          status_next       = kfc_pkg::ST_OK;
          if ((op == kfc_pkg::OP_POP) || (op == kfc_pkg::OP_REMOVE)) begin
            state_next = kfc_pkg::S_SHIFT_RD;
          end else begin
            done_next        = 1'b1;
            queue_empty_next = 1'b0;
            state_next       = kfc_pkg::S_IDLE;
          end
        end else if (idx_inc == occ) begin
          // scanned every entry without a match
          done_next         = 1'b1;
          status_next       = kfc_pkg::ST_NOTFOUND;
          found_key_next    = '0;
          found_handle_next = '0;
          queue_empty_next  = 1'b0;
          state_next        = kfc_pkg::S_IDLE;
        end else begin
          idx_next   = idx_inc;
          state_next = kfc_pkg::S_LOOK;
        end
      end

      kfc_pkg::S_SHIFT_RD: begin
        if (idx_inc < occ) begin
          rd_addr    = idx_inc[AW-1:0];
          state_next = kfc_pkg::S_SHIFT_WR;
        end else begin
          // gap has reached the tail
          occ_next         = occ - OW'(1);
          done_next        = 1'b1;
          queue_empty_next = (occ == OW'(1));
          state_next       = kfc_pkg::S_IDLE;
        end
      end

      kfc_pkg::S_SHIFT_WR: begin
        // move entry idx+1 down into slot idx
        wr_en      = 1'b1;
        wr_addr    = idx[AW-1:0];
        wr_data    = rd_data;
        idx_next   = idx_inc;
        state_next = kfc_pkg::S_SHIFT_RD;
      end

      default: begin
        state_next = kfc_pkg::S_IDLE;
      end
    endcase
  end

  // checks on the sequencer
  `KFC_ASSERT_NOW(a_occ_bound, 1'b1, occ <= FULL_COUNT, "occupancy beyond depth")
  `KFC_ASSERT_NEXT(a_cmd_progress, start && !busy, busy || done, "command dropped")
  `KFC_ASSERT_NOW(a_fail_zero, done && (status != kfc_pkg::ST_OK),
    (found_handle == '0) && (found_key == '0), "nonzero entry on failed command")
  `KFC_ASSERT_NOW(a_empty_flag, done, queue_empty == (occ == '0), "empty flag off")

endmodule

`default_nettype wire
